// ----- hdl/rcpd_pkg.sv -----
package rcpd_pkg;

  // Payload and register widths
  localparam int unsigned DATA_W         = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Stretch divide: quotient always fits in DATA_W bits, one bit per step
  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] IDX_MIN_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_MAX_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_MID_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_CENTER_BAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_END_BAND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_DZ_ENABLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_ST_ENABLE   = 3'd6;

  // Register reset values
  localparam logic [DATA_W-1:0] RST_MIN_WIDTH   = 16'd1000;
  localparam logic [DATA_W-1:0] RST_MAX_WIDTH   = 16'd2000;
  localparam logic [DATA_W-1:0] RST_MID_WIDTH   = 16'd1500;
  localparam logic [DATA_W-1:0] RST_CENTER_BAND = 16'd20;
  localparam logic [DATA_W-1:0] RST_END_BAND    = 16'd20;

  typedef struct packed {
    logic [DATA_W-1:0] min_width;
    logic [DATA_W-1:0] max_width;
    logic [DATA_W-1:0] mid_width;
    logic [DATA_W-1:0] center_band;
    logic [DATA_W-1:0] end_band;
    logic              dead_zone_enable;
    logic              stretch_enable;
  } rcpd_cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic item_ld;
    logic base_ld;
    logic bound_ld;
    logic map_ld;
    logic mul_ld;
    logic div_step;
    logic fix_ld;
    logic out_ld;
  } rcpd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
  } rcpd_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_BOUND,
    ST_MAP,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } rcpd_state_t;

endpackage

// ----- hdl/rcpd_in_if.sv -----
interface rcpd_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

// ----- hdl/rcpd_out_if.sv -----
interface rcpd_out_if;
  logic                        valid;
  logic                        ready;
  logic [rcpd_pkg::DATA_W-1:0] stick_value;
  logic                        pulse_done;

  modport source (output valid, output stick_value, output pulse_done, input ready);
  modport sink   (input valid, input stick_value, input pulse_done, output ready);
endinterface

// ----- hdl/rcpd_cfg_regs.sv -----
module rcpd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rcpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output rcpd_pkg::rcpd_cfg_t                 cfg
);
  import rcpd_pkg::*;

  rcpd_cfg_t cfg_r;

  // Register file, writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_width        <= RST_MIN_WIDTH;
      cfg_r.max_width        <= RST_MAX_WIDTH;
      cfg_r.mid_width        <= RST_MID_WIDTH;
      cfg_r.center_band      <= RST_CENTER_BAND;
      cfg_r.end_band         <= RST_END_BAND;
      cfg_r.dead_zone_enable <= 1'b0;
      cfg_r.stretch_enable   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        IDX_MIN_WIDTH:   cfg_r.min_width        <= cfg_wdata[DATA_W-1:0];
        IDX_MAX_WIDTH:   cfg_r.max_width        <= cfg_wdata[DATA_W-1:0];
        IDX_MID_WIDTH:   cfg_r.mid_width        <= cfg_wdata[DATA_W-1:0];
        IDX_CENTER_BAND: cfg_r.center_band      <= cfg_wdata[DATA_W-1:0];
        IDX_END_BAND:    cfg_r.end_band         <= cfg_wdata[DATA_W-1:0];
        IDX_DZ_ENABLE:   cfg_r.dead_zone_enable <= cfg_wdata[0];
        IDX_ST_ENABLE:   cfg_r.stretch_enable   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/rcpd_ctrl.sv -----
module rcpd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rcpd_pkg::rcpd_sts_t  sts,
  output rcpd_pkg::rcpd_cmd_t  cmd
);
  import rcpd_pkg::*;

  rcpd_state_t           state_r, state_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // State, divide step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_ld = 1'b1;
          state_nxt   = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd.base_ld = 1'b1;
        state_nxt   = ST_BOUND;
      end
      ST_BOUND: begin
        cmd.bound_ld = 1'b1;
        state_nxt    = ST_MAP;
      end
      ST_MAP: begin
        cmd.map_ld = 1'b1;
        state_nxt  = sts.need_div ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        cmd.mul_ld  = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd.fix_ld = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/rcpd_datapath.sv -----
module rcpd_datapath #(
  parameter int unsigned WIDTH_BITS = rcpd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rcpd_pkg::rcpd_cfg_t           cfg,
  input  rcpd_pkg::rcpd_cmd_t           cmd,
  output rcpd_pkg::rcpd_sts_t           sts,
  input  logic                          pin_level,
  output logic [rcpd_pkg::DATA_W-1:0]   stick_value,
  output logic                          pulse_done
);
  import rcpd_pkg::*;

  localparam int unsigned CMP_W = (WIDTH_BITS > DATA_W) ? WIDTH_BITS : DATA_W;
  // signed working width: sums of two or three widths with sign
  localparam int unsigned SW    = DATA_W + 3;

  localparam logic signed [SW-1:0] SAT_MAX = {{(SW - DATA_W){1'b0}}, {DATA_W{1'b1}}};

  function automatic logic signed [SW-1:0] sx(input logic [DATA_W-1:0] x);
    return $signed({{(SW - DATA_W){1'b0}}, x});
  endfunction

  function automatic logic [DATA_W-1:0] sat(input logic signed [SW-1:0] x);
    logic [DATA_W-1:0] r;
    if (x < 0) begin
      r = '0;
    end else if (x > SAT_MAX) begin
      r = '1;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Pulse capture state
  logic                   last_r;
  logic [WIDTH_BITS-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0]      held_r, held_nxt;
  logic                   seen_r;
  logic                   done_r;
  logic                   rise, fall;
  logic [CMP_W-1:0]       w_ext;

  always_comb begin
    rise  = pin_level & ~last_r;
    fall  = ~pin_level & last_r;
    if (rise) begin
      cnt_nxt = '0;
    end else if (cnt_r != '1) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
    // clamp the measured width; the low limit is tested first
    w_ext = CMP_W'(cnt_nxt);
    if (w_ext < CMP_W'(cfg.min_width)) begin
      held_nxt = cfg.min_width;
    end else if (w_ext > CMP_W'(cfg.max_width)) begin
      held_nxt = cfg.max_width;
    end else begin
      held_nxt = w_ext[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
      cnt_r  <= '0;
      held_r <= '0;
      seen_r <= 1'b0;
      done_r <= 1'b0;
    end else if (cmd.item_ld) begin
      last_r <= pin_level;
      cnt_r  <= cnt_nxt;
      done_r <= fall;
      if (fall) begin
        held_r <= held_nxt;
        seen_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // Midpoint and base width
  logic [DATA_W-1:0] span, mid_half, mid_val;

  always_comb begin
    span     = cfg.max_width - cfg.min_width;
    mid_half = cfg.min_width + (span >> 1);
    if (cfg.mid_width > cfg.min_width && cfg.mid_width < cfg.max_width) begin
      mid_val = cfg.mid_width;
    end else if (cfg.max_width < cfg.min_width) begin
      mid_val = cfg.min_width;
    end else begin
      mid_val = mid_half;
    end
  end

  logic [DATA_W-1:0] v_r, m_r;

  // ---------------------------------------------------------------
  // Dead zone boundaries
  logic signed [SW-1:0] up_lo_r, up_hi_r, dn_hi_r, dn_lo_r;

  // ---------------------------------------------------------------
  // Region select, direct result and divide operands
  logic signed [SW-1:0] vs, ms, d_up_x, d_up_den, d_dn_x, d_dn_den, k_up, k_dn, direct;
  logic                 need_div, neg;
  logic [DATA_W-1:0]    x_sel, k_sel, den_sel, off_sel;

  always_comb begin
    vs       = sx(v_r);
    ms       = sx(m_r);
    d_up_x   = vs - up_lo_r;
    d_up_den = up_hi_r - up_lo_r;
    d_dn_x   = vs - dn_lo_r;
    d_dn_den = dn_hi_r - dn_lo_r;
    k_up     = (sx(cfg.max_width) < ms) ? ms - sx(cfg.max_width) : sx(cfg.max_width) - ms;
    k_dn     = ms - sx(cfg.min_width);
    direct   = vs;
    need_div = 1'b0;
    neg      = 1'b0;
    x_sel    = '0;
    k_sel    = '0;
    den_sel  = '0;
    off_sel  = '0;
    if (cfg.dead_zone_enable) begin
      if (vs >= up_lo_r) begin
        // upper live range or upper end zone
        if (vs < up_hi_r) begin
          if (cfg.stretch_enable) begin
            need_div = 1'b1;
            neg      = sx(cfg.max_width) < ms;
            x_sel    = d_up_x[DATA_W-1:0];
            k_sel    = k_up[DATA_W-1:0];
            den_sel  = d_up_den[DATA_W-1:0];
            off_sel  = m_r;
          end else begin
            direct = vs - sx(cfg.center_band);
          end
        end else begin
          direct = cfg.stretch_enable ? sx(cfg.max_width) : up_hi_r - sx(cfg.center_band);
        end
      end else if (vs <= dn_hi_r) begin
        // lower live range or lower end zone
        if (vs > dn_lo_r) begin
          if (cfg.stretch_enable) begin
            need_div = 1'b1;
            x_sel    = d_dn_x[DATA_W-1:0];
            k_sel    = k_dn[DATA_W-1:0];
            den_sel  = d_dn_den[DATA_W-1:0];
            off_sel  = cfg.min_width;
          end else begin
            direct = vs + sx(cfg.center_band);
          end
        end else begin
          direct = cfg.stretch_enable ? sx(cfg.min_width) : dn_lo_r + sx(cfg.center_band);
        end
      end else begin
        // centre dead zone
        direct = ms;
      end
    end
  end

  assign sts.need_div = need_div;

  logic [DATA_W-1:0] x_r, k_r, den_r, off_r, result_r;
  logic              neg_r;

  // ---------------------------------------------------------------
  // Multiply then restoring divide, quotient shifts into quo_r
  logic [DATA_W-1:0]    rem_r, quo_r;
  logic [DATA_W:0]      shifted, trial;
  logic                 ge;
  logic signed [SW-1:0] fix_val;

  always_comb begin
    shifted = {rem_r, quo_r[DATA_W-1]};
    trial   = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
    fix_val = neg_r ? sx(off_r) - sx(quo_r) : sx(off_r) + sx(quo_r);
  end

  logic [DATA_W-1:0] stick_r;
  logic              pdone_r;

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.base_ld) begin
      v_r <= seen_r ? held_r : mid_val;
      m_r <= mid_val;
    end
    if (cmd.bound_ld) begin
      up_lo_r <= sx(m_r) + sx(cfg.center_band);
      up_hi_r <= sx(cfg.max_width) - sx(cfg.end_band);
      dn_hi_r <= sx(m_r) - sx(cfg.center_band);
      dn_lo_r <= sx(cfg.min_width) + sx(cfg.end_band);
    end
    if (cmd.map_ld) begin
      result_r <= sat(direct);
      x_r      <= x_sel;
      k_r      <= k_sel;
      den_r    <= den_sel;
      off_r    <= off_sel;
      neg_r    <= neg;
    end
    if (cmd.mul_ld) begin
      {rem_r, quo_r} <= x_r * k_r;
    end else if (cmd.div_step) begin
      rem_r <= ge ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], ge};
    end
    if (cmd.fix_ld) begin
      result_r <= sat(fix_val);
    end
    if (cmd.out_ld) begin
      stick_r <= result_r;
      pdone_r <= done_r;
    end
  end

  assign stick_value = stick_r;
  assign pulse_done  = pdone_r;

endmodule

// ----- hdl/rc_pulse_capture_deadzone_core.sv -----
// RC pulse width capture with dead zone mapping. Each input item is one pin
// sample taken on a one microsecond tick; each item gives exactly one result
// item carrying the held pulse width (after optional dead zone mapping) and a
// flag that the tick closed a pulse. The counter saturates at 2^WIDTH_BITS-1
// and the width is clamped to the min/max registers; until the first pulse
// the midpoint is reported. One item is worked at a time, through the base,
// bound, map and output states; when dead zones and stretch are both on and
// the width falls in a live range, a multiply, a 16-step restoring divide
// and a fix-up come between map and output. A finished result sits in an
// output register, so acceptance resumes while it waits to be taken.
// Configuration writes must be made only while the block is idle.
module rc_pulse_capture_deadzone_core #(
  parameter int unsigned WIDTH_BITS = rcpd_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rcpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  rcpd_in_if.sink                          in_item,
  rcpd_out_if.source                       out_item
);
  import rcpd_pkg::*;

  rcpd_cfg_t cfg;
  rcpd_cmd_t cmd;
  rcpd_sts_t sts;

  // Configuration registers
  rcpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sequencer
  rcpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Capture, mapping and divide
  rcpd_datapath #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .pin_level   (in_item.pin_level),
    .stick_value (out_item.stick_value),
    .pulse_done  (out_item.pulse_done)
  );

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcpd_pkg::*;

  localparam longint STICK_MAX = (longint'(1) << DATA_W) - 1;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [DATA_W-1:0] stick_value;
    logic              pulse_done;
  } stick_item_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rcpd_in_if  in_ch();
  rcpd_out_if out_ch();

  rc_pulse_capture_deadzone_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_ch),
    .out_item  (out_ch)
  );

  // Register copy held by the testbench
  logic [DATA_W-1:0] r_min, r_max, r_mid, r_cband, r_eband;
  logic              r_dz, r_st;

  // Capture state
  logic                      m_last;
  logic [COUNT_BITS_DEF-1:0] m_ticks;
  logic [DATA_W-1:0]         m_held;
  logic                      m_seen;

  stick_item_t pending_sticks[$];
  int          mismatch_count;
  int          items_sent;
  bit          in_gaps_on;
  bit          out_gaps_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Limit on run time
  initial begin
    #30ms;
    $display("rc_pulse_capture_deadzone_core regression: fail");
    $finish;
  end

  // Center of travel: requested value only if strictly inside the limits
  function automatic logic [DATA_W-1:0] center_point();
    if (r_mid > r_min && r_mid < r_max) return r_mid;
    if (r_max < r_min) return r_min;
    return DATA_W'(r_min + (r_max - r_min) / 2);
  endfunction

  function automatic longint rescale(input longint v, input longint lo_in,
                                     input longint hi_in, input longint lo_out,
                                     input longint hi_out);
    longint den;
    den = hi_in - lo_in;
    if (den <= 0) return lo_out;
    return (v - lo_in) * (hi_out - lo_out) / den + lo_out;
  endfunction

  // Dead zone mapping, exact signed math then saturated to 16 bits
  function automatic logic [DATA_W-1:0] shape_width(input logic [DATA_W-1:0] raw);
    longint v, m, c, e, lo, hi, r;
    v  = raw;
    m  = center_point();
    c  = r_cband;
    e  = r_eband;
    lo = r_min;
    hi = r_max;
    if (!r_dz) return raw;
    if (v >= m + c) begin
      if (v < hi - e) r = r_st ? rescale(v, m + c, hi - e, m, hi) : v - c;
      else            r = r_st ? hi : hi - e - c;
    end else if (v <= m - c) begin
      if (v > lo + e) r = r_st ? rescale(v, lo + e, m - c, lo, m) : v + c;
      else            r = r_st ? lo : lo + e + c;
    end else begin
      r = m;
    end
    if (r < 0) r = 0;
    if (r > STICK_MAX) r = STICK_MAX;
    return r[DATA_W-1:0];
  endfunction

  // Advance the capture state by one tick and queue the expected item
  function automatic void capture_tick(input logic level);
    stick_item_t want;
    logic [DATA_W-1:0] base;
    want.pulse_done = 1'b0;
    if (level && !m_last) m_ticks = '0;
    else if (m_ticks != '1) m_ticks = m_ticks + 1'b1;
    if (!level && m_last) begin
      if (m_ticks < r_min)      m_held = r_min;
      else if (m_ticks > r_max) m_held = r_max;
      else                      m_held = m_ticks;
      m_seen = 1'b1;
      want.pulse_done = 1'b1;
    end
    m_last = level;
    base = m_seen ? m_held : center_point();
    want.stick_value = shape_width(base);
    pending_sticks.push_back(want);
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: mismatch: %s", $realtime, what);
  endtask

  // Results: optional random stall per item, then check vs oldest expectation
  initial begin
    int wait_cycles;
    stick_item_t want;
    out_ch.ready = 1'b0;
    forever begin
      wait_cycles = out_gaps_on ? $urandom_range(0, 7) : 0;
      @(negedge clk);
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (pending_sticks.size() == 0) begin
        note_mismatch($sformatf("unexpected item stick=%0d done=%0b",
                                out_ch.stick_value, out_ch.pulse_done));
      end else begin
        want = pending_sticks.pop_front();
        if (out_ch.stick_value !== want.stick_value ||
            out_ch.pulse_done !== want.pulse_done)
          note_mismatch($sformatf("stick exp %0d got %0d, done exp %0b got %0b",
                                  want.stick_value, out_ch.stick_value,
                                  want.pulse_done, out_ch.pulse_done));
      end
    end
  end

  // Send one pin sample, with an optional random gap ahead of it
  task automatic send_tick(input logic level);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pin_level <= level;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    capture_tick(level);
    items_sent++;
  endtask

  task automatic send_pulse(input int high_ticks);
    repeat (high_ticks) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Drain all results, then give the block time to go idle
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_sticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      IDX_MIN_WIDTH:   r_min   = data;
      IDX_MAX_WIDTH:   r_max   = data;
      IDX_MID_WIDTH:   r_mid   = data;
      IDX_CENTER_BAND: r_cband = data;
      IDX_END_BAND:    r_eband = data;
      IDX_DZ_ENABLE:   r_dz    = data[0];
      IDX_ST_ENABLE:   r_st    = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [15:0] mid, input logic [15:0] cb,
                            input logic [15:0] eb, input logic dz, input logic st);
    write_reg(IDX_MIN_WIDTH, lo);
    write_reg(IDX_MAX_WIDTH, hi);
    write_reg(IDX_MID_WIDTH, mid);
    write_reg(IDX_CENTER_BAND, cb);
    write_reg(IDX_END_BAND, eb);
    write_reg(IDX_DZ_ENABLE, {15'd0, dz});
    write_reg(IDX_ST_ENABLE, {15'd0, st});
  endtask

  // Mostly clean pulses with random widths, some random pin noise
  task automatic run_pulses(input int n_items, input int hi_cap);
    int start;
    int kind;
    start = items_sent;
    while (items_sent - start < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        repeat ($urandom_range(1, 4)) send_tick(1'b0);
        send_pulse($urandom_range(1, hi_cap));
      end else begin
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
      end
    end
    send_tick(1'b0);
  endtask

  // Before the first pulse the midpoint is reported, dead zones on and off
  task automatic test_reset_midpoint();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    repeat (3) send_tick(1'b0);
    settle();
    write_reg(IDX_DZ_ENABLE, 16'd1);
    repeat (2) send_tick(1'b0);
    repeat (2) send_tick(1'b1);
    settle();
  endtask

  // Clamping, center band shift and stretch on a short travel
  task automatic test_dead_zones();
    set_config(16'd2, 16'd8, 16'd5, 16'd1, 16'd1, 1'b1, 1'b0);
    send_tick(1'b0);
    send_pulse(1);
    send_pulse(4);
    send_pulse(6);
    settle();
    write_reg(IDX_ST_ENABLE, 16'd1);
    send_pulse(3);
    send_pulse(4);
    send_pulse(6);
    send_pulse(10);
    settle();
  endtask

  // All-ones and all-zeros register values, full 16-bit travel
  task automatic test_extremes();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_pulse(1);
    settle();
    set_config(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b1, 1'b0);
    send_pulse(2);
    settle();
    set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1, 1'b0);
    send_pulse(1);
    settle();
    set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b1, 1'b1);
    send_pulse(3);
    settle();
  endtask

  // Max below min: midpoint is min, clamp order picks min first
  task automatic test_inverted_limits();
    set_config(16'd9, 16'd4, 16'd6, 16'd1, 16'd1, 1'b1, 1'b0);
    send_pulse(2);
    send_pulse(12);
    settle();
    write_reg(IDX_ST_ENABLE, 16'd1);
    send_pulse(6);
    send_pulse(3);
    settle();
  endtask

  // Random small-scale settings, each with a burst of pulses
  task automatic test_random_configs(input int phases, input int per_phase);
    logic [15:0] lo, hi, tmp;
    int mode;
    int hi_cap;
    repeat (phases) begin
      lo = 16'($urandom_range(0, 12));
      hi = lo + 16'($urandom_range(1, 30));
      if ($urandom_range(0, 7) == 0) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      set_config(lo, hi, 16'($urandom_range(0, 45)), 16'($urandom_range(0, 8)),
                 16'($urandom_range(0, 8)), $urandom_range(0, 4) != 0,
                 1'($urandom_range(0, 1)));
      mode        = $urandom_range(0, 3);
      in_gaps_on  = mode[0];
      out_gaps_on = mode[1];
      hi_cap = ((hi > lo) ? hi : lo) + 6;
      if (hi_cap > 48) hi_cap = 48;
      run_pulses(per_phase, hi_cap);
      settle();
    end
  endtask

  // Fully random register contents
  task automatic test_wild_config(input int n_items);
    write_reg(IDX_MIN_WIDTH, 16'($urandom()));
    write_reg(IDX_MAX_WIDTH, 16'($urandom()));
    write_reg(IDX_MID_WIDTH, 16'($urandom()));
    write_reg(IDX_CENTER_BAND, 16'($urandom()));
    write_reg(IDX_END_BAND, 16'($urandom()));
    write_reg(IDX_DZ_ENABLE, 16'($urandom()));
    write_reg(IDX_ST_ENABLE, 16'($urandom()));
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    run_pulses(n_items, 40);
    settle();
  endtask

  // Main sequence
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.pin_level = 1'b0;
    r_min   = RST_MIN_WIDTH;
    r_max   = RST_MAX_WIDTH;
    r_mid   = RST_MID_WIDTH;
    r_cband = RST_CENTER_BAND;
    r_eband = RST_END_BAND;
    r_dz    = 1'b0;
    r_st    = 1'b0;
    m_last  = 1'b0;
    m_ticks = '0;
    m_held  = '0;
    m_seen  = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    in_gaps_on     = 1'b1;
    out_gaps_on    = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_midpoint();
    test_dead_zones();
    test_extremes();
    test_inverted_limits();
    test_random_configs(6, 55);
    test_wild_config(40);

    if (mismatch_count == 0 && pending_sticks.size() == 0) begin
      $display("rc_pulse_capture_deadzone_core regression: pass");
    end else begin
      $display("rc_pulse_capture_deadzone_core regression: fail");
    end
    $finish;
  end

endmodule
